// File: hw/rtl/lap_stopwatch_display_writer_assert.svh
// Assertion helpers shared by the stopwatch display writer modules.
// Both expect clk_i and rst_ni in scope.
`ifndef LAP_STOPWATCH_DISPLAY_WRITER_ASSERT_SVH
`define LAP_STOPWATCH_DISPLAY_WRITER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define LSDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define LSDW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/lsdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsdw_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_KEY   = 2'd1,
    REQ_LIGHT = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_FROZEN  = 2'd2
  } run_mode_e;

  typedef enum logic {
    OP_DIGITS = 1'b0,
    OP_LEVEL  = 1'b1
  } cmd_op_e;

  localparam logic [6:0] HUND_MAX   = 7'd99;
  localparam logic [5:0] SEC_MAX    = 6'd59;
  localparam logic [5:0] MIN_MAX    = 6'd59;
  localparam logic [4:0] HRS_MAX    = 5'd23;
  localparam logic [7:0] DP_BIT     = 8'h80;
  localparam logic [3:0] LEVEL_ADDR = 4'hA;
  localparam int         CMD_DEPTH  = 2;

  // One queued job for the write sequencer. For digit jobs, pairs 0..last_pair
  // are written; vals[i] is the value shown on digit pair i.
  typedef struct packed {
    cmd_op_e         op;
    logic [1:0]      last_pair;
    logic [3:0][6:0] vals;
    logic [3:0]      level;
  } cmd_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // sample * 15 / 255 == sample / 17; 241 / 4096 is exact over 0..255.
  function automatic logic [3:0] level_of(logic [7:0] sample);
    logic [15:0] prod;
    prod = 16'(sample) * 16'd241;
    return prod[15:12];
  endfunction

  // x / 10 == (x * 103) >> 10 for x below 179.
  function automatic digits_t split_digits(logic [6:0] v);
    logic [13:0] prod;
    logic [6:0]  tens_x10;
    digits_t     d;
    prod     = 14'(v) * 14'd103;
    d.tens   = prod[13:10];
    tens_x10 = 7'(d.tens) * 7'd10;
    d.ones   = 4'(v - tens_x10);
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lap_stopwatch_display_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// Stopwatch with lap hold that emits display controller register writes
// (addr 1..8 digits, hundredths on 1/2 up to hours on 7/8, addr 10 intensity).
// Items are taken at one per cycle while the job queue (two entries) has
// room; each item is classified and the counters updated in that cycle. A
// sequencer behind the queue sends one write per cycle, while the reader
// keeps popping, through a one-entry output register. An item causes two
// writes for a tick that only moves the hundredths, one for a light sample,
// up to eight for a tick that ripples to the hours or a press that unfreezes
// the display, none for items that write nothing. With the queue and output
// register idle, the job is queued, then its first write is registered.
module lap_stopwatch_display_writer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] req_type_i,
  input  wire logic       key_level_i,
  input  wire logic [7:0] light_sample_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      reg_addr_o,
  output logic [7:0]      reg_data_o,
  output logic            last_o
);
  import lsdw_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic front_valid, cmd_empty, cmd_pop;

  lsdw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (push && !full),
    .req_type_i     (req_type_i),
    .key_level_i    (key_level_i),
    .light_sample_i (light_sample_i),
    .cmd_o          (front_cmd),
    .cmd_valid_o    (front_valid)
  );

  lsdw_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (cmd_pop),
    .rd_data_o (head_cmd),
    .empty_o   (cmd_empty)
  );

  lsdw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .reg_addr_o  (reg_addr_o),
    .reg_data_o  (reg_data_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/lsdw_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lsdw_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [1:0]    req_type_i,
  input  wire logic          key_level_i,
  input  wire logic [7:0]    light_sample_i,
  output lsdw_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o
);
  import lsdw_pkg::*;

  logic [6:0] hund_q, hund_d, hund_inc;
  logic [5:0] sec_q, sec_d, sec_inc;
  logic [5:0] min_q, min_d, min_inc;
  logic [4:0] hrs_q, hrs_d, hrs_inc;
  logic       wrap_h, wrap_s, wrap_m, wrap_hr;
  logic       tick, press;
  run_mode_e  mode_q, mode_d;

  assign tick  = accept_i && (req_type_e'(req_type_i) == REQ_TICK);
  assign press = accept_i && (req_type_e'(req_type_i) == REQ_KEY) && key_level_i;

  assign hund_inc = hund_q + 7'd1;
  assign sec_inc  = sec_q + 6'd1;
  assign min_inc  = min_q + 6'd1;
  assign hrs_inc  = hrs_q + 5'd1;
  assign wrap_h   = hund_inc > HUND_MAX;
  assign wrap_s   = sec_inc > SEC_MAX;
  assign wrap_m   = min_inc > MIN_MAX;
  assign wrap_hr  = hrs_inc > HRS_MAX;

  // Counters keep running while the display is frozen.
  always_comb begin
    hund_d = hund_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hrs_d  = hrs_q;
    if (tick && mode_q != MODE_STOPPED) begin
      hund_d = wrap_h ? 7'd0 : hund_inc;
      if (wrap_h) begin
        sec_d = wrap_s ? 6'd0 : sec_inc;
        if (wrap_s) begin
          min_d = wrap_m ? 6'd0 : min_inc;
          if (wrap_m) begin
            hrs_d = wrap_hr ? 5'd0 : hrs_inc;
          end
        end
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    if (press) begin
      unique case (mode_q)
        MODE_STOPPED: mode_d = MODE_RUNNING;
        MODE_RUNNING: mode_d = MODE_FROZEN;
        default:      mode_d = MODE_RUNNING;
      endcase
    end
  end

  // Classify the item into a write job; post-update values are what is shown.
  always_comb begin
    cmd_valid_o     = 1'b0;
    cmd_o.op        = OP_DIGITS;
    cmd_o.last_pair = 2'd0;
    cmd_o.vals      = {7'(hrs_d), 7'(min_d), 7'(sec_d), hund_d};
    cmd_o.level     = level_of(light_sample_i);
    if (accept_i) begin
      unique case (req_type_e'(req_type_i))
        REQ_TICK: begin
          if (mode_q != MODE_STOPPED && mode_q != MODE_FROZEN) begin
            cmd_valid_o     = 1'b1;
            cmd_o.last_pair = !wrap_h ? 2'd0 : !wrap_s ? 2'd1 : !wrap_m ? 2'd2 : 2'd3;
          end
        end
        REQ_KEY: begin
          if (key_level_i && mode_q != MODE_STOPPED && mode_q != MODE_RUNNING) begin
            cmd_valid_o     = 1'b1;
            cmd_o.last_pair = 2'd3;
          end
        end
        REQ_LIGHT: begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = OP_LEVEL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hund_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hrs_q  <= '0;
      mode_q <= MODE_STOPPED;
    end else begin
      hund_q <= hund_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hrs_q  <= hrs_d;
      mode_q <= mode_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lsdw_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lsdw_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire lsdw_pkg::cmd_t wr_data_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output lsdw_pkg::cmd_t     rd_data_o,
  output logic               empty_o
);
  import lsdw_pkg::*;
  `include "lap_stopwatch_display_writer_assert.svh"

  localparam int PtrW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CntW = $clog2(CMD_DEPTH + 1);

  cmd_t            mem_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = count_q == CntW'(CMD_DEPTH);
  assign empty_o   = count_q == '0;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (wr_i && !rd_i) begin
      count_d = count_q + CntW'(1);
    end else if (rd_i && !wr_i) begin
      count_d = count_q - CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `LSDW_ASSERT(a_count_bound, count_q <= CntW'(CMD_DEPTH), "job queue count overflow")
  `LSDW_ASSERT_NEVER(a_no_write_full, wr_i && full_o, "job written into full queue")
  `LSDW_ASSERT_NEVER(a_no_read_empty, rd_i && empty_o, "job read from empty queue")

endmodule
`default_nettype wire

// File: hw/rtl/lsdw_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lsdw_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire lsdw_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [3:0]         reg_addr_o,
  output logic [7:0]         reg_data_o,
  output logic               last_o
);
  import lsdw_pkg::*;
  `include "lap_stopwatch_display_writer_assert.svh"

  logic       out_valid_q, out_valid_d;
  logic [2:0] step_q, step_d;
  logic [3:0] addr_q, w_addr;
  logic [7:0] data_q, w_data;
  logic       last_q, w_last;
  logic       load;
  digits_t    digits;

  assign load   = cmd_valid_i && (!out_valid_q || pop_i);
  // step_q[2:1] picks the digit pair, step_q[0] ones (0) or tens (1).
  assign digits = split_digits(cmd_i.vals[step_q[2:1]]);

  always_comb begin
    unique case (cmd_i.op)
      OP_DIGITS: begin
        w_addr = {1'b0, step_q} + 4'd1;
        w_data = step_q[0] ? {4'd0, digits.tens} : (DP_BIT | {4'd0, digits.ones});
        w_last = step_q[0] && (step_q[2:1] == cmd_i.last_pair);
      end
      OP_LEVEL: begin
        w_addr = LEVEL_ADDR;
        w_data = {4'd0, cmd_i.level};
        w_last = 1'b1;
      end
      default: begin
        w_addr = LEVEL_ADDR;
        w_data = '0;
        w_last = 1'b1;
      end
    endcase
  end

  assign cmd_pop_o = load && w_last;

  always_comb begin
    step_d = step_q;
    if (load) begin
      step_d = w_last ? 3'd0 : step_q + 3'd1;
    end
    priority if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= w_addr;
      data_q <= w_data;
      last_q <= w_last;
    end
  end

  assign empty_o    = !out_valid_q;
  assign reg_addr_o = addr_q;
  assign reg_data_o = data_q;
  assign last_o     = last_q;

  `LSDW_ASSERT(a_step_in_job,
    !(cmd_valid_i && cmd_i.op == OP_DIGITS) || (step_q[2:1] <= cmd_i.last_pair),
    "write step ran past the last digit pair")
  `LSDW_ASSERT(a_level_single, !(cmd_valid_i && cmd_i.op == OP_LEVEL) || (step_q == 3'd0),
    "intensity job entered mid-sequence")

endmodule
`default_nettype wire

// File: dv/lap_stopwatch_display_writer_tb.sv
`timescale 1ns / 1ps
module lap_stopwatch_display_writer_tb;
  import lsdw_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         SEC_TICKS  = 100;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } disp_write_t;

  class stopwatch_scoreboard;
    logic [6:0]  hund;
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [4:0]  hrs;
    run_mode_e   mode;
    disp_write_t item_writes[$];
    disp_write_t pending_writes[$];
    int unsigned fail_count;

    function new();
      hund       = '0;
      secs       = '0;
      mins       = '0;
      hrs        = '0;
      mode       = MODE_STOPPED;
      fail_count = 0;
    endfunction

    function void add_write(logic [3:0] addr, logic [7:0] data);
      disp_write_t w;
      w.addr = addr;
      w.data = data;
      w.last = 1'b0;
      item_writes.push_back(w);
    endfunction

    // Frozen display writes nothing; a value past its limit shows as 00.
    function void show_pair(logic [3:0] addr, int value, int limit);
      int ones;
      int tens;
      ones = 0;
      tens = 0;
      if (mode == MODE_FROZEN) return;
      if (value <= limit) begin
        tens = value / 10;
        ones = value % 10;
      end
      add_write(addr, DP_BIT | 8'(ones));
      add_write(addr + 4'd1, 8'(tens));
    endfunction

    function void advance_tick();
      if (mode == MODE_STOPPED) return;
      hund = hund + 7'd1;
      show_pair(4'd1, int'(hund), int'(HUND_MAX));
      if (hund > HUND_MAX) begin
        hund = '0;
        secs = secs + 6'd1;
        show_pair(4'd3, int'(secs), int'(SEC_MAX));
        if (secs > SEC_MAX) begin
          secs = '0;
          mins = mins + 6'd1;
          show_pair(4'd5, int'(mins), int'(MIN_MAX));
          if (mins > MIN_MAX) begin
            mins = '0;
            hrs  = hrs + 5'd1;
            show_pair(4'd7, int'(hrs), int'(HRS_MAX));
            if (hrs > HRS_MAX) hrs = '0;
          end
        end
      end
    endfunction

    function void press_key();
      case (mode)
        MODE_STOPPED: mode = MODE_RUNNING;
        MODE_RUNNING: mode = MODE_FROZEN;
        default: begin
          // Leave frozen: rewrite every digit.
          mode = MODE_RUNNING;
          show_pair(4'd1, int'(hund), int'(HUND_MAX));
          show_pair(4'd3, int'(secs), int'(SEC_MAX));
          show_pair(4'd5, int'(mins), int'(MIN_MAX));
          show_pair(4'd7, int'(hrs), int'(HRS_MAX));
        end
      endcase
    endfunction

    function void note_item(logic [1:0] kind, logic level, logic [7:0] sample);
      item_writes.delete();
      case (kind)
        REQ_TICK:  advance_tick();
        REQ_KEY:   if (level) press_key();
        REQ_LIGHT: add_write(LEVEL_ADDR, 8'((int'(sample) * 15) / 255));
        default:   ;
      endcase
      if (item_writes.size() > 0) begin
        item_writes[item_writes.size() - 1].last = 1'b1;
        foreach (item_writes[i]) pending_writes.push_back(item_writes[i]);
      end
    endfunction

    function void check_write(logic [3:0] addr, logic [7:0] data, logic last);
      disp_write_t w;
      if (pending_writes.size() == 0) begin
        fail_count++;
        $display("%0t: write expected none actual addr %0d data 0x%02h last %0b",
                 $time, addr, data, last);
        return;
      end
      w = pending_writes.pop_front();
      if (addr !== w.addr) begin
        fail_count++;
        $display("%0t: reg_addr expected %0d actual %0d", $time, w.addr, addr);
      end
      if (data !== w.data) begin
        fail_count++;
        $display("%0t: reg_data expected 0x%02h actual 0x%02h", $time, w.data, data);
      end
      if (last !== w.last) begin
        fail_count++;
        $display("%0t: last expected %0b actual %0b", $time, w.last, last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [1:0] req_type_i;
  logic       key_level_i;
  logic [7:0] light_sample_i;
  logic       empty;
  logic       pop;
  logic [3:0] reg_addr_o;
  logic [7:0] reg_data_o;
  logic       last_o;

  stopwatch_scoreboard board;
  bit                  long_hold_req;
  int                  no_gap_left;

  lap_stopwatch_display_writer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .key_level_i   (key_level_i),
    .light_sample_i(light_sample_i),
    .empty         (empty),
    .pop           (pop),
    .reg_addr_o    (reg_addr_o),
    .reg_data_o    (reg_data_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Transfers on both sides are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_item(req_type_i, key_level_i, light_sample_i);
      if (pop && !empty) board.check_write(reg_addr_o, reg_data_o, last_o);
    end
  end

  // Hold each item until the block takes it; return at the next falling edge.
  task automatic send_item(logic [1:0] kind, logic level, logic [7:0] sample);
    req_type_i     = kind;
    key_level_i    = level;
    light_sample_i = sample;
    push           = 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (r < 5) begin
      no_gap_left = $urandom_range(10, 30);
    end else if (r < 50) begin
      n = 0;
    end else if (r < 90) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(8, 40);
    end
    if (n > 0) begin
      push = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_item(REQ_TICK, 1'($urandom), 8'($urandom));
    end else if (r < 70) begin
      send_item(REQ_KEY, 1'($urandom), 8'($urandom));
    end else if (r < 92) begin
      send_item(REQ_LIGHT, 1'($urandom), 8'($urandom));
    end else begin
      send_item(REQ_UNUSED, 1'($urandom), 8'($urandom));
    end
  endtask

  // Result side: short and long stalls, free-running stretches, one long hold.
  initial begin
    int stall_left;
    int free_left;
    int r;
    stall_left = 0;
    free_left  = 0;
    pop        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 400;
        free_left     = 0;
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else if (free_left > 0) begin
        pop = 1'b1;
        free_left--;
      end else begin
        r   = $urandom_range(0, 99);
        pop = 1'b1;
        if (r < 15) begin
          pop        = 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r < 18) begin
          pop        = 1'b0;
          stall_left = $urandom_range(10, 40);
        end else if (r < 25) begin
          free_left = $urandom_range(30, 60);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int skip_ticks;
    int sent;
    board          = new();
    long_hold_req  = 1'b0;
    no_gap_left    = 0;
    rst_ni         = 1'b0;
    push           = 1'b0;
    req_type_i     = REQ_TICK;
    key_level_i    = 1'b0;
    light_sample_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Intensity extremes and both bit patterns.
    send_item(REQ_LIGHT, 1'b0, 8'd0);
    send_item(REQ_LIGHT, 1'b1, 8'd255);
    send_item(REQ_LIGHT, 1'b0, 8'd16);
    sender_gap();
    send_item(REQ_LIGHT, 1'b0, 8'd17);
    send_item(REQ_LIGHT, 1'b1, 8'hAA);
    send_item(REQ_LIGHT, 1'b0, 8'h55);
    // Ignored while stopped: tick, release, unused request type.
    send_item(REQ_TICK, 1'b1, 8'hFF);
    send_item(REQ_KEY, 1'b0, 8'h00);
    send_item(REQ_UNUSED, 1'b1, 8'hFF);
    // First press starts the watch silently, then run, freeze, unfreeze.
    send_item(REQ_KEY, 1'b1, 8'h00);
    send_item(REQ_KEY, 1'b0, 8'h00);
    repeat (3) send_item(REQ_TICK, 1'b0, 8'h00);
    send_item(REQ_KEY, 1'b1, 8'h00);
    repeat (2) send_item(REQ_TICK, 1'b0, 8'h00);
    send_item(REQ_LIGHT, 1'b0, 8'd128);
    send_item(REQ_KEY, 1'b1, 8'h00);
    send_item(REQ_TICK, 1'b0, 8'h00);

    // Freeze and fast-forward to just short of the next second, then cross
    // it live so the hundredths wrap and the seconds carry show up.
    send_item(REQ_KEY, 1'b1, 8'h00);
    skip_ticks = SEC_TICKS - 4 - int'(board.hund);
    repeat (skip_ticks) send_item(REQ_TICK, 1'b0, 8'h00);
    send_item(REQ_KEY, 1'b1, 8'h00);
    repeat (6) send_item(REQ_TICK, 1'b0, 8'h00);
    sender_gap();

    sent = 0;
    while (sent < 90) begin
      if (sent == 30) begin
        // Stall the result side and keep offering so the input backs up.
        long_hold_req = 1'b1;
        repeat (12) begin
          send_item(REQ_LIGHT, 1'($urandom), 8'($urandom));
          sent++;
        end
      end
      send_random_item();
      sent++;
      sender_gap();
    end

    push = 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
